@@ sv/qmi_pkg.sv @@
// Shared types, constants and ring-index helpers for queue_with_middle_insert.
// No dependencies; every other file imports this package.
package qmi_pkg;

    localparam int CAPACITY   = 1024;
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int IDX_W      = $clog2(HALF_DEPTH);
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int TOT_W      = CNT_W + 1;
    localparam int DATA_W     = 32;

    // opcodes
    localparam logic [1:0] OP_PUSH_BACK = 2'd0;
    localparam logic [1:0] OP_PUSH_MID  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_MOVE
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic [1:0]               status;
    } result_t;

    // head + offset, wrapped once (offset never exceeds HALF_DEPTH)
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(idx) + (CNT_W + 1)'(ofs);
        if (s >= (CNT_W + 1)'(HALF_DEPTH))
        begin
            s = s - (CNT_W + 1)'(HALF_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(HALF_DEPTH - 1) : idx - IDX_W'(1);
    endfunction

endpackage

@@ sv/qmi_half_ram.sv @@
// One half ring of the queue: simple dual-port RAM, registered read.
// Depends on qmi_pkg for widths and the request struct.
module qmi_half_ram
    import qmi_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store_reg [HALF_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= store_reg[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/qmi_seq.sv @@
// Operation sequencer: half-ring pointers and counts, RAM requests, rebalance move.
// Depends on qmi_pkg; drives two qmi_half_ram instances in the top level.
module qmi_seq
    import qmi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_opcode,
    input  logic [DATA_W-1:0] in_value,
    output ram_req_t          front_req,
    output ram_req_t          back_req,
    input  logic [DATA_W-1:0] front_rdata,
    input  logic [DATA_W-1:0] back_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    seq_state_t state_reg, state_next;

    logic [IDX_W-1:0] fh_reg, fh_next;
    logic [IDX_W-1:0] bh_reg, bh_next;
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic [CNT_W-1:0] bc_reg, bc_next;

    // per-request context carried into the move cycle
    logic              mv_reg;
    logic              fwd_reg;
    logic              pop_ok_reg;
    logic [1:0]        stat_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [DATA_W-1:0] val_reg;

    logic              accept;
    logic              is_push, is_pop, full, push_ok, pop_ok, mv, fwd;
    logic [TOT_W-1:0]  total;
    logic [IDX_W-1:0]  bwaddr, fh1, bh1, tail;
    logic [CNT_W-1:0]  fc1, bc1;
    logic [1:0]        stat;

    assign accept = in_valid && in_ready;

    // request decode and pointer arithmetic
    always_comb
    begin
        is_push = (in_opcode == OP_PUSH_BACK) || (in_opcode == OP_PUSH_MID);
        is_pop  = (in_opcode == OP_POP_FRONT);
        total   = TOT_W'(fc_reg) + TOT_W'(bc_reg);
        full    = (total >= TOT_W'(CAPACITY)) || (bc_reg >= CNT_W'(HALF_DEPTH));
        push_ok = is_push && !full;
        pop_ok  = is_pop && (fc_reg != '0);
        bwaddr  = (in_opcode == OP_PUSH_MID) ? ring_prev(bh_reg) : ring_add(bh_reg, bc_reg);

        fh1 = fh_reg;
        bh1 = bh_reg;
        fc1 = fc_reg;
        bc1 = bc_reg;
        if (push_ok)
        begin
            bc1 = bc_reg + CNT_W'(1);
            if (in_opcode == OP_PUSH_MID)
            begin
                bh1 = bwaddr;
            end
        end
        else if (pop_ok)
        begin
            fh1 = ring_add(fh_reg, CNT_W'(1));
            fc1 = fc_reg - CNT_W'(1);
        end

        mv   = (push_ok || pop_ok) && (bc1 > fc1) && (fc1 < CNT_W'(HALF_DEPTH));
        // rebalance read hits the entry written this cycle
        fwd  = push_ok && (bh1 == bwaddr);
        tail = ring_add(fh1, fc1);

        priority if (is_push && full)
            stat = STAT_FULL;
        else if (is_pop && !pop_ok)
            stat = STAT_EMPTY;
        else
            stat = STAT_OK;
    end

    // FSM next state and outputs
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        fh_next    = fh_reg;
        bh_next    = bh_reg;
        fc_next    = fc_reg;
        bc_next    = bc_reg;

        back_req.we    = 1'b0;
        back_req.waddr = bwaddr;
        back_req.wdata = in_value;
        back_req.re    = 1'b0;
        back_req.raddr = bh1;

        front_req.we    = 1'b0;
        front_req.waddr = tail_reg;
        front_req.wdata = fwd_reg ? val_reg : back_rdata;
        front_req.re    = 1'b0;
        front_req.raddr = fh_reg;

        res.popped = pop_ok_reg ? $signed(front_rdata) : '0;
        res.status = stat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    back_req.we  = push_ok;
                    back_req.re  = mv;
                    front_req.re = pop_ok;
                    fh_next = fh1;
                    if (mv)
                    begin
                        bh_next = ring_add(bh1, CNT_W'(1));
                        bc_next = bc1 - CNT_W'(1);
                        fc_next = fc1 + CNT_W'(1);
                    end
                    else
                    begin
                        bh_next = bh1;
                        bc_next = bc1;
                        fc_next = fc1;
                    end
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // the tail write repeats harmlessly while the result stalls
                front_req.we = mv_reg;
                res_valid    = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fh_reg    <= '0;
            bh_reg    <= '0;
            fc_reg    <= '0;
            bc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fh_reg    <= fh_next;
            bh_reg    <= bh_next;
            fc_reg    <= fc_next;
            bc_reg    <= bc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mv_reg     <= mv;
            fwd_reg    <= fwd;
            pop_ok_reg <= pop_ok;
            stat_reg   <= stat;
            tail_reg   <= tail;
            val_reg    <= in_value;
        end
    end

endmodule

@@ sv/queue_with_middle_insert.sv @@
// Top level of queue_with_middle_insert: stream ports, output register, two half rings.
// Depends on qmi_pkg, qmi_half_ram and qmi_seq.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[1:0] opcode, [33:2] value
//  m_*     | out | m_tvalid/m_tready  | m_tdata[31:0] popped, [33:32] status
//
// Each request passes through S_IDLE and S_MOVE: the accept cycle in S_IDLE
// issues the RAM reads and the back-half write, then S_MOVE, with the registered
// RAM reads back, finishes the rebalance move into the front-half tail and
// produces the result. A finished result waits in the output register while the
// next request is accepted; a second result stalls the sequencer only when that
// register is still held by m_tready low. Reset (rst_n low, asynchronous)
// empties the queue; RAM contents are left as they are.
module queue_with_middle_insert
    import qmi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] opcode, [33:2] value, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] popped, [33:32] status, [39:34] zero
);

    ram_req_t          front_req, back_req;
    logic [DATA_W-1:0] front_rdata, back_rdata;
    logic              res_valid, res_ready;
    result_t           res;

    logic              out_valid_reg;
    result_t           out_reg;

    qmi_half_ram u_front_ram (
        .clk   (clk),
        .req   (front_req),
        .rdata (front_rdata)
    );

    qmi_half_ram u_back_ram (
        .clk   (clk),
        .req   (back_req),
        .rdata (back_rdata)
    );

    qmi_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tdata[1:0]),
        .in_value    (s_tdata[33:2]),
        .front_req   (front_req),
        .back_req    (back_req),
        .front_rdata (front_rdata),
        .back_rdata  (back_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register: free when empty or draining this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.popped};

    // a request is never taken in the cycle right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // with the output register empty at accept, the result goes through S_MOVE straight into the output register
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing after request");

    // only a successful pop carries a nonzero value
    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] != STAT_OK) |-> (m_tdata[31:0] == '0))
        else $error("nonzero value with error status");

    // status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] == STAT_OK) || (m_tdata[33:32] == STAT_EMPTY)
                  || (m_tdata[33:32] == STAT_FULL))
        else $error("bad status code");

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for queue_with_middle_insert: random and directed requests
// checked against a two-half-ring predictor kept in a scoreboard class.
// Depends on qmi_pkg and the queue_with_middle_insert RTL.
module tb_top
    import qmi_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
    localparam int RX_HOLD_CYCLES = 400;   // one long receiver hold-off
    localparam int RX_HOLD_AT     = 200;   // ... starting after this many results
    localparam int RANDOM_ITEMS   = 720;
    localparam int SEGMENT_ITEMS  = 25;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Predicts each result from its own copy of the two half rings and holds
    // the results still owed by the block, oldest first.
    class qmi_scoreboard;
        logic [DATA_W-1:0] front_ring [HALF_DEPTH];
        logic [DATA_W-1:0] back_ring  [HALF_DEPTH];
        int unsigned front_rd, front_cnt, back_rd, back_cnt;
        result_t     owed_results [$];
        int unsigned mismatches, checked, peak_fill;
        int unsigned ops_seen [4];
        int unsigned status_seen [4];

        function new();
            front_rd = 0; front_cnt = 0; back_rd = 0; back_cnt = 0;
            mismatches = 0; checked = 0; peak_fill = 0;
            foreach (ops_seen[i]) ops_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned occupancy();
            return front_cnt + back_cnt;
        endfunction

        function int unsigned wrap(input int unsigned p);
            return (p >= HALF_DEPTH) ? p - HALF_DEPTH : p;
        endfunction

        // keep the front half at ceil(m/2): move back head to front tail
        function void rebalance();
            if (back_cnt > front_cnt && front_cnt < HALF_DEPTH)
            begin
                front_ring[wrap(front_rd + front_cnt)] = back_ring[back_rd];
                back_rd = wrap(back_rd + 1);
                back_cnt--;
                front_cnt++;
            end
        endfunction

        function void record_request(input logic [1:0] op, input logic [DATA_W-1:0] value);
            result_t r;
            r.popped = '0;
            r.status = STAT_OK;
            ops_seen[op]++;
            case (op)
                OP_PUSH_BACK, OP_PUSH_MID:
                begin
                    if (occupancy() >= CAPACITY || back_cnt >= HALF_DEPTH)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        if (op == OP_PUSH_BACK)
                        begin
                            back_ring[wrap(back_rd + back_cnt)] = value;
                        end
                        else
                        begin
                            // middle slot is just ahead of the back-half head
                            back_rd = (back_rd == 0) ? HALF_DEPTH - 1 : back_rd - 1;
                            back_ring[back_rd] = value;
                        end
                        back_cnt++;
                        rebalance();
                    end
                end
                OP_POP_FRONT:
                begin
                    if (front_cnt == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        r.popped = front_ring[front_rd];
                        front_rd = wrap(front_rd + 1);
                        front_cnt--;
                        rebalance();
                    end
                end
                default: ;  // unused opcode: no change, ok status
            endcase
            if (occupancy() > peak_fill)
            begin
                peak_fill = occupancy();
            end
            owed_results.push_back(r);
        endfunction

        function void check_result(input logic [39:0] beat);
            result_t got;
            result_t want;
            got.popped = beat[31:0];
            got.status = beat[33:32];
            status_seen[got.status]++;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing outstanding: popped %0d, status %0d",
                       got.popped, got.status);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.popped !== want.popped)
            begin
                $error("popped: expected %0d, got %0d", want.popped, got.popped);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    qmi_scoreboard sb = new();
    int unsigned   idle_cycles = 0;
    int unsigned   results_taken = 0;
    bit            sender_burst = 1'b0;

    queue_with_middle_insert u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // hold one request on the bus until the block takes it
    task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, value, op};
        do @(posedge clk); while (!s_tready);
        sb.record_request(op, value);
    endtask

    task automatic sender_gap();
        int unsigned n;
        n = sender_burst ? 0 : pick_gap();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_and_idle(input logic [1:0] op, input logic [DATA_W-1:0] value);
        send_request(op, value);
        sender_gap();
    endtask

    // sender pause: nothing offered until every owed result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.owed_results.size() != 0);
    endtask

    function automatic logic [1:0] pick_push();
        return ($urandom_range(0, 1) == 0) ? OP_PUSH_BACK : OP_PUSH_MID;
    endfunction

    // receiver: random stalls, stall-free stretches, and one long hold-off
    initial
    begin
        int unsigned n;
        bit          held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && results_taken >= RX_HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                n = (((results_taken / 64) % 3) == 1) ? 0 : pick_gap();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
            results_taken++;
        end
    end

    // any handshake resets the count; a long silence means the block hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned counted;
        int unsigned push_pct;
        logic [1:0]  op;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, unused opcode, value extremes, both push kinds,
        // draining to empty, middle push into an empty queue
        send_and_idle(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_and_idle(OP_UNUSED,    32'hFFFF_FFFF);
        send_and_idle(OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_and_idle(OP_PUSH_BACK, 32'h8000_0000);
        send_and_idle(OP_PUSH_MID,  32'h0000_0000);
        send_and_idle(OP_PUSH_MID,  32'hFFFF_FFFF);
        send_and_idle(OP_PUSH_MID,  32'h5555_5555);
        send_and_idle(OP_PUSH_BACK, 32'hAAAA_AAAA);
        repeat (6) send_and_idle(OP_POP_FRONT, 32'h0);
        send_and_idle(OP_POP_FRONT, 32'h0);
        send_and_idle(OP_UNUSED,    32'h0);
        send_and_idle(OP_PUSH_MID,  32'h1234_5678);
        send_and_idle(OP_POP_FRONT, 32'hFFFF_FFFF);
        wait_drained();

        // random: segments with push-heavy, balanced or pop-heavy mixes;
        // unused opcodes sprinkled in as noise and not counted
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ((counted % SEGMENT_ITEMS) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                sender_burst = ($urandom_range(0, 4) == 0);
            end
            if ($urandom_range(0, 99) < 3)
            begin
                send_and_idle(OP_UNUSED, pick_value());
                continue;
            end
            op = ($urandom_range(0, 99) < push_pct) ? pick_push() : OP_POP_FRONT;
            send_and_idle(op, pick_value());
            counted++;
        end
        sender_burst = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Checked %0d results: %0d push-back, %0d push-middle, %0d pop, %0d unused op;",
                 sb.checked, sb.ops_seen[OP_PUSH_BACK], sb.ops_seen[OP_PUSH_MID],
                 sb.ops_seen[OP_POP_FRONT], sb.ops_seen[OP_UNUSED]);
        $display("statuses ok %0d, empty %0d, full %0d; peak fill %0d of %0d.",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY],
                 sb.status_seen[STAT_FULL], sb.peak_fill, CAPACITY);
        if (sb.mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
